// ===== rtl/core/http2_settings_frame_checker_top_assert.svh =====
// Assertion macros for the HTTP/2 SETTINGS frame checker.
// Included by the checker module; no other dependencies.
`ifndef HTTP2_SETTINGS_FRAME_CHECKER_TOP_ASSERT_SVH
`define HTTP2_SETTINGS_FRAME_CHECKER_TOP_ASSERT_SVH

// Property checked at every rising edge of clk, ignored while rst is high.
`define HSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, reset included.
`define HSFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hsfc_pkg.sv =====
// Shared types and constants for the HTTP/2 SETTINGS frame checker.
// No dependencies.
package hsfc_pkg;

  localparam int LenW    = 24;
  localparam int SidW    = 31;
  localparam int WinW    = 31;
  localparam int FsizeW  = 24;

  localparam logic [LenW-1:0]   BufferSizeReset = 24'd16384;
  localparam logic [WinW-1:0]   WindowReset     = 31'd65535;
  localparam logic [FsizeW-1:0] FrameSizeReset  = 24'd16384;

  localparam logic [15:0] ID_ENABLE_PUSH    = 16'd2;
  localparam logic [15:0] ID_INITIAL_WINDOW = 16'd4;
  localparam logic [15:0] ID_MAX_FRAME      = 16'd5;

  localparam logic [2:0] LastEntryByte = 3'd5;

  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_PROTOCOL   = 2'd1,
    ST_FLOW       = 2'd2,
    ST_FRAME_SIZE = 2'd3
  } status_t;

  typedef struct packed {
    command_t          command;
    logic              ack_flag;
    logic [LenW-1:0]   frame_length;
    logic [SidW-1:0]   stream_id;
    logic [7:0]        data_byte;
  } item_t;

  typedef struct packed {
    logic               frame_done;
    status_t            status;
    logic               window_changed;
    logic signed [31:0] window_delta;
    logic [WinW-1:0]    initial_window;
    logic [FsizeW-1:0]  max_frame_size;
    logic               ack_accepted;
  } result_t;

endpackage

// ===== rtl/core/hsfc_in_reg.sv =====
// Input register of the SETTINGS frame checker.
// Depends on hsfc_pkg for the item type.
module hsfc_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hsfc_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output hsfc_pkg::item_t item
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/hsfc_engine.sv =====
// Frame state and combinational check logic of the SETTINGS frame checker.
// Depends on hsfc_pkg for the item and result types and constants.
module hsfc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hsfc_pkg::LenW-1:0]     cfg_wdata,
  input  logic                          fire,
  input  hsfc_pkg::item_t               item,
  output hsfc_pkg::result_t             result
);

  logic                           in_payload, in_payload_next;
  logic [hsfc_pkg::LenW-1:0]      bytes_left, bytes_left_next;
  logic [2:0]                     entry_byte_count, entry_byte_count_next;
  logic [39:0]                    entry_shift, entry_shift_next;
  logic                           dropping, dropping_next;
  logic [hsfc_pkg::WinW-1:0]      window_setting, window_setting_next;
  logic [hsfc_pkg::FsizeW-1:0]    frame_size_setting, frame_size_setting_next;
  logic [hsfc_pkg::LenW-1:0]      buffer_size;

  logic [hsfc_pkg::LenW-1:0]      bytes_dec;
  logic                           last;
  logic [15:0]                    entry_id;
  logic [31:0]                    entry_val;
  logic [31:0]                    delta_calc;
  logic                           len_mult6;
  logic                           fail;
  hsfc_pkg::status_t              fail_status;

  function automatic logic [1:0] mod3_24(input logic [23:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [1:0] r;
    s1 = '0;
    for (int i = 0; i < 12; i++) begin
      s1 = s1 + 6'(v[2*i +: 2]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
    case (s2)
      4'd1, 4'd4, 4'd7: r = 2'd1;
      4'd2, 4'd5, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  assign bytes_dec  = bytes_left - hsfc_pkg::LenW'(1);
  assign last       = (bytes_dec == '0);
  assign entry_id   = entry_shift[39:24];
  assign entry_val  = {entry_shift[23:0], item.data_byte};
  assign delta_calc = entry_val - {1'b0, window_setting};
  assign len_mult6  = !item.frame_length[0] && (mod3_24(item.frame_length) == 2'd0);

  always_comb begin
    in_payload_next         = in_payload;
    bytes_left_next         = bytes_left;
    entry_byte_count_next   = entry_byte_count;
    entry_shift_next        = entry_shift;
    dropping_next           = dropping;
    window_setting_next     = window_setting;
    frame_size_setting_next = frame_size_setting;
    fail                    = 1'b0;
    fail_status             = hsfc_pkg::ST_OK;
    result                  = '0;
    result.status           = hsfc_pkg::ST_OK;

    if (item.command == hsfc_pkg::CMD_HEADER) begin
      in_payload_next       = 1'b0;
      dropping_next         = 1'b0;
      bytes_left_next       = '0;
      entry_byte_count_next = '0;
      entry_shift_next      = '0;
      result.frame_done     = 1'b1;
      if (item.ack_flag) begin
        if (item.frame_length != '0) begin
          result.status = hsfc_pkg::ST_FRAME_SIZE;
        end else begin
          result.ack_accepted = 1'b1;
        end
      end else if (item.stream_id != '0) begin
        result.status = hsfc_pkg::ST_PROTOCOL;
      end else if (!len_mult6 || (item.frame_length > buffer_size)) begin
        result.status = hsfc_pkg::ST_FRAME_SIZE;
      end else if (item.frame_length != '0) begin
        result.frame_done = 1'b0;
        in_payload_next   = 1'b1;
        bytes_left_next   = item.frame_length;
      end
    end else if (in_payload) begin
      bytes_left_next = bytes_dec;
      if (dropping) begin
        if (last) begin
          in_payload_next       = 1'b0;
          dropping_next         = 1'b0;
          entry_byte_count_next = '0;
          entry_shift_next      = '0;
        end
      end else begin
        if (entry_byte_count < hsfc_pkg::LastEntryByte) begin
          entry_shift_next      = {entry_shift[31:0], item.data_byte};
          entry_byte_count_next = entry_byte_count + 3'd1;
        end else begin
          entry_shift_next      = '0;
          entry_byte_count_next = '0;
          if (entry_id == hsfc_pkg::ID_INITIAL_WINDOW) begin
            if (entry_val[31]) begin
              fail        = 1'b1;
              fail_status = hsfc_pkg::ST_FLOW;
            end else begin
              result.window_changed = 1'b1;
              result.window_delta   = delta_calc;
              window_setting_next   = entry_val[30:0];
            end
          end else if (entry_id == hsfc_pkg::ID_MAX_FRAME) begin
            if ((entry_val[31:24] != '0) || (entry_val[23:14] == '0)) begin
              fail        = 1'b1;
              fail_status = hsfc_pkg::ST_PROTOCOL;
            end else begin
              frame_size_setting_next = entry_val[23:0];
            end
          end else if (entry_id == hsfc_pkg::ID_ENABLE_PUSH) begin
            if (entry_val[31:1] != '0) begin
              fail        = 1'b1;
              fail_status = hsfc_pkg::ST_PROTOCOL;
            end
          end
        end
        if (fail) begin
          result.frame_done = 1'b1;
          result.status     = fail_status;
          if (last) begin
            in_payload_next = 1'b0;
          end else begin
            dropping_next = 1'b1;
          end
        end else if (last) begin
          in_payload_next       = 1'b0;
          entry_byte_count_next = '0;
          entry_shift_next      = '0;
          result.frame_done     = 1'b1;
        end
      end
    end

    result.initial_window = window_setting_next;
    result.max_frame_size = frame_size_setting_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload         <= 1'b0;
      bytes_left         <= '0;
      entry_byte_count   <= '0;
      entry_shift        <= '0;
      dropping           <= 1'b0;
      window_setting     <= hsfc_pkg::WindowReset;
      frame_size_setting <= hsfc_pkg::FrameSizeReset;
    end else if (fire) begin
      in_payload         <= in_payload_next;
      bytes_left         <= bytes_left_next;
      entry_byte_count   <= entry_byte_count_next;
      entry_shift        <= entry_shift_next;
      dropping           <= dropping_next;
      window_setting     <= window_setting_next;
      frame_size_setting <= frame_size_setting_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= hsfc_pkg::BufferSizeReset;
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
    end
  end

endmodule

// ===== rtl/core/hsfc_out_reg.sv =====
// Result register of the SETTINGS frame checker.
// Depends on hsfc_pkg for the result type.
module hsfc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  hsfc_pkg::result_t result,
  output logic              advance,
  output logic              fire,
  output logic              out_valid,
  input  logic              out_stall,
  output hsfc_pkg::result_t out_result
);

  assign advance = !out_valid || !out_stall;
  assign fire    = item_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

endmodule

// ===== rtl/core/http2_settings_frame_checker_top.sv =====
// HTTP/2 SETTINGS frame checker, top level: couples input register, check
// logic and result register. Depends on hsfc_pkg and the hsfc_* modules.
//
// Each item is a frame header (command 0) or one payload byte (command 1)
// and yields exactly one result item. An item is taken every clock cycle
// whenever the result side keeps up. Its result item is offered once the
// input register and then the result register around the combinational
// check logic have held it. While out_stall holds, the block keeps up to
// two items and then stalls its input. Write buffer_size only while no
// item is in flight.
module http2_settings_frame_checker_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hsfc_pkg::LenW-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic                       ack_flag,
  input  logic [hsfc_pkg::LenW-1:0]  frame_length,
  input  logic [hsfc_pkg::SidW-1:0]  stream_id,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       frame_done,
  output logic [1:0]                 status,
  output logic                       window_changed,
  output logic signed [31:0]         window_delta,
  output logic [hsfc_pkg::WinW-1:0]  initial_window,
  output logic [hsfc_pkg::FsizeW-1:0] max_frame_size,
  output logic                       ack_accepted
);

  hsfc_pkg::item_t   in_item;
  hsfc_pkg::item_t   item;
  hsfc_pkg::result_t result;
  hsfc_pkg::result_t out_result;
  logic              item_valid;
  logic              advance;
  logic              fire;

  assign in_item.command      = hsfc_pkg::command_t'(command);
  assign in_item.ack_flag     = ack_flag;
  assign in_item.frame_length = frame_length;
  assign in_item.stream_id    = stream_id;
  assign in_item.data_byte    = data_byte;

  hsfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hsfc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  hsfc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .fire       (fire),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign frame_done     = out_result.frame_done;
  assign status         = out_result.status;
  assign window_changed = out_result.window_changed;
  assign window_delta   = out_result.window_delta;
  assign initial_window = out_result.initial_window;
  assign max_frame_size = out_result.max_frame_size;
  assign ack_accepted   = out_result.ack_accepted;

endmodule

// ===== rtl/core/hsfc_checker.sv =====
// Port-level assertions for the HTTP/2 SETTINGS frame checker, bound to the
// top level. Depends on hsfc_pkg and the assertion macro header.
`include "http2_settings_frame_checker_top_assert.svh"

module hsfc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        frame_done,
  input logic [1:0]                  status,
  input logic                        window_changed,
  input logic signed [31:0]          window_delta,
  input logic [hsfc_pkg::FsizeW-1:0] max_frame_size,
  input logic                        ack_accepted
);

  `HSFC_ASSERT(a_status_needs_done, out_valid && !frame_done |-> status == hsfc_pkg::ST_OK, "Error status on an item that does not end the frame.")
  `HSFC_ASSERT(a_delta_only_on_change, out_valid && !window_changed |-> window_delta == 32'sd0, "Window delta without a window change.")
  `HSFC_ASSERT(a_ack_is_clean_end, out_valid && ack_accepted |-> frame_done && status == hsfc_pkg::ST_OK && !window_changed, "Acknowledgement not reported as a clean frame end.")
  `HSFC_ASSERT(a_frame_size_floor, out_valid |-> max_frame_size >= hsfc_pkg::FrameSizeReset, "Max frame size below the protocol minimum.")
  `HSFC_ASSERT_ALWAYS(a_stalled_result_holds, !rst && out_valid && out_stall |=> rst || (out_valid && $stable(status) && $stable(frame_done)), "Stalled result item changed.")

endmodule

bind http2_settings_frame_checker_top hsfc_checker u_hsfc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .frame_done     (frame_done),
  .status         (status),
  .window_changed (window_changed),
  .window_delta   (window_delta),
  .max_frame_size (max_frame_size),
  .ack_accepted   (ack_accepted)
);

// ===== tb/sv/tb_http2_settings_frame_checker_top.sv =====
`timescale 1ns / 100ps
// Testbench for the HTTP/2 SETTINGS frame checker top level.
// Drives header and payload items, predicts or looks up every result, compares field by field.
// Depends on hsfc_pkg and http2_settings_frame_checker_top.
module tb_http2_settings_frame_checker_top;

  localparam logic [31:0] FrameSizeMin = 32'd16384;
  localparam logic [31:0] FrameSizeMax = 32'd16777215;
  localparam int unsigned EntryLen = 6;
  localparam int unsigned IdlePercent = 27;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned DrainCycles = 4;

  typedef struct {
    hsfc_pkg::item_t   it;
    bit                typed;
    hsfc_pkg::result_t want;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [hsfc_pkg::LenW-1:0]   cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic                        command;
  logic                        ack_flag;
  logic [hsfc_pkg::LenW-1:0]   frame_length;
  logic [hsfc_pkg::SidW-1:0]   stream_id;
  logic [7:0]                  data_byte;
  logic                        out_valid;
  logic                        out_stall;
  logic                        frame_done;
  logic [1:0]                  status;
  logic                        window_changed;
  logic signed [31:0]          window_delta;
  logic [hsfc_pkg::WinW-1:0]   initial_window;
  logic [hsfc_pkg::FsizeW-1:0] max_frame_size;
  logic                        ack_accepted;

  bit quiet;
  bit hold_pending;
  int unsigned mismatch_count;
  int unsigned useful_items;
  hsfc_pkg::result_t expected_results[$];
  stim_row_t directed_rows[$];

  logic [hsfc_pkg::LenW-1:0]   buf_limit = hsfc_pkg::BufferSizeReset;
  bit                          open_frame;
  bit                          discarding;
  logic [hsfc_pkg::LenW-1:0]   remaining;
  logic [2:0]                  entry_count;
  logic [39:0]                 entry_bytes;
  logic [hsfc_pkg::WinW-1:0]   cur_window = hsfc_pkg::WindowReset;
  logic [hsfc_pkg::FsizeW-1:0] cur_frame_size = hsfc_pkg::FrameSizeReset;

  http2_settings_frame_checker_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .ack_flag       (ack_flag),
    .frame_length   (frame_length),
    .stream_id      (stream_id),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_done     (frame_done),
    .status         (status),
    .window_changed (window_changed),
    .window_delta   (window_delta),
    .initial_window (initial_window),
    .max_frame_size (max_frame_size),
    .ack_accepted   (ack_accepted)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("FAIL http2_settings_frame_checker_top");
    $finish;
  end

  function automatic hsfc_pkg::result_t settings_predict(input hsfc_pkg::item_t it);
    hsfc_pkg::result_t r;
    logic [47:0]       entry;
    logic [15:0]       id;
    logic [31:0]       val;
    bit                fail;
    bit                last;
    r = '0;
    r.status = hsfc_pkg::ST_OK;
    fail = 1'b0;
    if (it.command == hsfc_pkg::CMD_HEADER) begin
      open_frame = 1'b0;
      discarding = 1'b0;
      remaining = '0;
      entry_count = '0;
      entry_bytes = '0;
      r.frame_done = 1'b1;
      if (it.ack_flag) begin
        if (it.frame_length != 0) r.status = hsfc_pkg::ST_FRAME_SIZE;
        else r.ack_accepted = 1'b1;
      end else if (it.stream_id != 0) begin
        r.status = hsfc_pkg::ST_PROTOCOL;
      end else if (it.frame_length % EntryLen != 0 || it.frame_length > buf_limit) begin
        r.status = hsfc_pkg::ST_FRAME_SIZE;
      end else if (it.frame_length != 0) begin
        open_frame = 1'b1;
        remaining = it.frame_length;
        r.frame_done = 1'b0;
      end
    end else if (open_frame) begin
      remaining = remaining - 1'b1;
      last = (remaining == 0);
      if (discarding) begin
        if (last) begin
          open_frame = 1'b0;
          discarding = 1'b0;
        end
      end else begin
        if (entry_count < hsfc_pkg::LastEntryByte) begin
          entry_bytes = {entry_bytes[31:0], it.data_byte};
          entry_count = entry_count + 1'b1;
        end else begin
          entry = {entry_bytes, it.data_byte};
          id = entry[47:32];
          val = entry[31:0];
          entry_bytes = '0;
          entry_count = '0;
          if (id == hsfc_pkg::ID_INITIAL_WINDOW) begin
            if (val[31]) begin
              fail = 1'b1;
              r.status = hsfc_pkg::ST_FLOW;
            end else begin
              r.window_delta = val - {1'b0, cur_window};
              r.window_changed = 1'b1;
              cur_window = val[hsfc_pkg::WinW-1:0];
            end
          end else if (id == hsfc_pkg::ID_MAX_FRAME) begin
            if (val < FrameSizeMin || val > FrameSizeMax) begin
              fail = 1'b1;
              r.status = hsfc_pkg::ST_PROTOCOL;
            end else begin
              cur_frame_size = val[hsfc_pkg::FsizeW-1:0];
            end
          end else if (id == hsfc_pkg::ID_ENABLE_PUSH && val > 32'd1) begin
            fail = 1'b1;
            r.status = hsfc_pkg::ST_PROTOCOL;
          end
        end
        if (fail) begin
          r.frame_done = 1'b1;
          if (last) open_frame = 1'b0;
          else discarding = 1'b1;
        end else if (last) begin
          open_frame = 1'b0;
          r.frame_done = 1'b1;
        end
      end
    end
    r.initial_window = cur_window;
    r.max_frame_size = cur_frame_size;
    return r;
  endfunction

  function automatic hsfc_pkg::result_t plain_result(input bit done,
                                                     input hsfc_pkg::status_t st,
                                                     input bit ack);
    hsfc_pkg::result_t r;
    r = '0;
    r.frame_done = done;
    r.status = st;
    r.initial_window = hsfc_pkg::WindowReset;
    r.max_frame_size = hsfc_pkg::FrameSizeReset;
    r.ack_accepted = ack;
    return r;
  endfunction

  function automatic hsfc_pkg::item_t header_item(input bit ack,
                                                  input logic [hsfc_pkg::LenW-1:0] len,
                                                  input logic [hsfc_pkg::SidW-1:0] sid);
    hsfc_pkg::item_t it;
    it.command = hsfc_pkg::CMD_HEADER;
    it.ack_flag = ack;
    it.frame_length = len;
    it.stream_id = sid;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic hsfc_pkg::item_t byte_item(input logic [7:0] b);
    hsfc_pkg::item_t it;
    it.command = hsfc_pkg::CMD_PAYLOAD;
    it.ack_flag = 1'($urandom);
    it.frame_length = hsfc_pkg::LenW'($urandom);
    it.stream_id = hsfc_pkg::SidW'($urandom);
    it.data_byte = b;
    return it;
  endfunction

  function automatic logic [15:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return hsfc_pkg::ID_INITIAL_WINDOW;
    if (r < 55) return hsfc_pkg::ID_MAX_FRAME;
    if (r < 75) return hsfc_pkg::ID_ENABLE_PUSH;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] pick_value(input logic [15:0] id);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (id == hsfc_pkg::ID_INITIAL_WINDOW) begin
      if (r < 15) return $urandom | 32'h8000_0000;
      if (r < 22) return 32'h7FFF_FFFF;
      if (r < 28) return 32'd0;
      return $urandom & 32'h7FFF_FFFF;
    end
    if (id == hsfc_pkg::ID_MAX_FRAME) begin
      if (r < 15) return $urandom_range(0, 16383);
      if (r < 25) return $urandom | 32'h0100_0000;
      if (r < 30) return FrameSizeMin;
      if (r < 35) return FrameSizeMax;
      return $urandom_range(16384, 16777215);
    end
    if (id == hsfc_pkg::ID_ENABLE_PUSH) begin
      if (r < 20) return $urandom;
      return $urandom_range(0, 1);
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_result(input hsfc_pkg::result_t got, input hsfc_pkg::result_t want);
    if (got.frame_done !== want.frame_done)
      report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.window_changed !== want.window_changed)
      report_mismatch("window_changed", 32'(got.window_changed), 32'(want.window_changed));
    if (got.window_delta !== want.window_delta)
      report_mismatch("window_delta", got.window_delta, want.window_delta);
    if (got.initial_window !== want.initial_window)
      report_mismatch("initial_window", 32'(got.initial_window), 32'(want.initial_window));
    if (got.max_frame_size !== want.max_frame_size)
      report_mismatch("max_frame_size", 32'(got.max_frame_size), 32'(want.max_frame_size));
    if (got.ack_accepted !== want.ack_accepted)
      report_mismatch("ack_accepted", 32'(got.ack_accepted), 32'(want.ack_accepted));
  endtask

  always @(posedge clk) begin : result_monitor
    hsfc_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.frame_done = frame_done;
      got.status = hsfc_pkg::status_t'(status);
      got.window_changed = window_changed;
      got.window_delta = window_delta;
      got.initial_window = initial_window;
      got.max_frame_size = max_frame_size;
      got.ack_accepted = ack_accepted;
      if (expected_results.size() == 0) report_mismatch("unexpected result item", 0, 0);
      else check_result(got, expected_results.pop_front());
    end
  end

  initial begin : receiver
    int unsigned held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        for (held = 0; held < HoldCycles; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= (!quiet && $urandom_range(0, 99) < IdlePercent);
    end
  end

  task automatic send_item(input hsfc_pkg::item_t it, input bit typed,
                           input hsfc_pkg::result_t want);
    hsfc_pkg::result_t pred;
    while (!quiet && $urandom_range(0, 99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.command;
    ack_flag <= it.ack_flag;
    frame_length <= it.frame_length;
    stream_id <= it.stream_id;
    data_byte <= it.data_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.command == hsfc_pkg::CMD_HEADER || open_frame) useful_items++;
    pred = settings_predict(it);
    expected_results.push_back(typed ? want : pred);
  endtask

  task automatic add_row(input hsfc_pkg::item_t it, input bit typed,
                         input hsfc_pkg::result_t want);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_entry(input logic [15:0] id, input logic [31:0] val);
    logic [47:0] e;
    e = {id, val};
    for (int k = 5; k >= 0; k--) add_row(byte_item(e[k*8 +: 8]), 1'b0, '0);
  endtask

  task automatic send_entry(input logic [15:0] id, input logic [31:0] val);
    logic [47:0] e;
    e = {id, val};
    for (int k = 5; k >= 0; k--) send_item(byte_item(e[k*8 +: 8]), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [hsfc_pkg::LenW-1:0] v);
    drain_results();
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    buf_limit = v;
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    logic [31:0] len;
    logic [15:0] id;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      send_item(header_item(1'b0, hsfc_pkg::LenW'(n * EntryLen), '0), 1'b0, '0);
      for (int e = 0; e < n; e++) begin
        id = pick_id();
        send_entry(id, pick_value(id));
      end
    end else if (kind < 68) begin
      len = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom;
      send_item(header_item(1'b1, len[hsfc_pkg::LenW-1:0], hsfc_pkg::SidW'($urandom)),
                1'b0, '0);
    end else if (kind < 80) begin
      case ($urandom_range(0, 2))
        0: len = $urandom_range(0, 1) ? $urandom : EntryLen;
        1: begin
          len = $urandom & 32'h00FF_FFFF;
          if (len % EntryLen == 0) len = len + 1;
        end
        default: len = (buf_limit / EntryLen + 1 + $urandom_range(0, 3)) * EntryLen;
      endcase
      if (len > FrameSizeMax || (len % EntryLen == 0 && len <= buf_limit))
        send_item(header_item(1'b0, hsfc_pkg::LenW'($urandom),
                              hsfc_pkg::SidW'($urandom_range(1, 32'h7FFF_FFFF))), 1'b0, '0);
      else
        send_item(header_item(1'b0, len[hsfc_pkg::LenW-1:0], '0), 1'b0, '0);
    end else if (kind < 90) begin
      if (buf_limit < EntryLen) len = EntryLen;
      else if (buf_limit / EntryLen > 4 && $urandom_range(0, 3) != 0)
        len = EntryLen * $urandom_range(1, 4);
      else len = EntryLen * $urandom_range(1, buf_limit / EntryLen);
      send_item(header_item(1'b0, len[hsfc_pkg::LenW-1:0], '0), 1'b0, '0);
      cut = $urandom_range(0, (len > 9) ? 8 : len - 1);
      repeat (cut) send_item(byte_item(8'($urandom)), 1'b0, '0);
      send_item(header_item(1'($urandom_range(0, 1)), '0, '0), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 3)) send_item(byte_item(8'($urandom)), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned target;
    target = useful_items + n_items;
    while (useful_items < target) random_frame();
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = hsfc_pkg::CMD_HEADER;
    ack_flag = 1'b0;
    frame_length = '0;
    stream_id = '0;
    data_byte = '0;

    add_row(byte_item(8'hA5), 1'b1, plain_result(1'b0, hsfc_pkg::ST_OK, 1'b0));
    add_row(header_item(1'b1, 24'd0, '0), 1'b1, plain_result(1'b1, hsfc_pkg::ST_OK, 1'b1));
    add_row(header_item(1'b1, 24'hFF_FFFF, 31'h7FFF_FFFF), 1'b1,
            plain_result(1'b1, hsfc_pkg::ST_FRAME_SIZE, 1'b0));
    add_row(header_item(1'b0, 24'd6, 31'h7FFF_FFFF), 1'b1,
            plain_result(1'b1, hsfc_pkg::ST_PROTOCOL, 1'b0));
    add_row(header_item(1'b0, 24'd7, '0), 1'b1,
            plain_result(1'b1, hsfc_pkg::ST_FRAME_SIZE, 1'b0));
    add_row(header_item(1'b0, 24'd16386, '0), 1'b1,
            plain_result(1'b1, hsfc_pkg::ST_FRAME_SIZE, 1'b0));
    add_row(header_item(1'b0, 24'd0, '0), 1'b1, plain_result(1'b1, hsfc_pkg::ST_OK, 1'b0));
    add_row(header_item(1'b0, 24'd18, '0), 1'b0, '0);
    add_entry(hsfc_pkg::ID_INITIAL_WINDOW, 32'h7FFF_FFFF);
    add_entry(hsfc_pkg::ID_MAX_FRAME, 32'h0000_3FFF);
    repeat (3) add_row(byte_item(8'($urandom)), 1'b0, '0);
    add_row(header_item(1'b1, 24'd0, '0), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

    write_buffer_size(24'hFF_FFFF);
    run_phase(130);
    drain_results();
    run_phase(120);
    write_buffer_size(24'd0);
    run_phase(80);
    write_buffer_size(24'd30);
    quiet = 1'b1;
    run_phase(170);
    drain_results();
    quiet = 1'b0;
    write_buffer_size(hsfc_pkg::BufferSizeReset);
    hold_pending = 1'b1;
    run_phase(250);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS http2_settings_frame_checker_top");
    end else begin
      $display("FAIL http2_settings_frame_checker_top");
    end
    $finish;
  end

endmodule
